[rtl/sliding_window_max_spread_defines.svh]
// Assertion macros for the sliding window spread block.
// Used by the checker; expects clk and rst_n in scope.
`ifndef SLIDING_WINDOW_MAX_SPREAD_DEFINES_SVH
`define SLIDING_WINDOW_MAX_SPREAD_DEFINES_SVH

// same-cycle implication
`define SWMS_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("swms: same-cycle check failed");

// next-cycle implication
`define SWMS_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("swms: next-cycle check failed");

`endif

[rtl/swms_pkg.sv]
// Shared types and constants for the sliding window spread block.
// No dependencies; imported by swms_alu, the top level and the bench.
package swms_pkg;

    localparam int SAMPLE_W       = 32;
    localparam int WINDOW_W       = 11;
    localparam int PADDR_W        = 2;
    localparam int PDATA_W        = 32;
    localparam int DEF_MAX_WINDOW = 1024;

    localparam logic [PADDR_W-1:0]  REG_WINDOW_SIZE_ADDR = 2'd0;
    localparam logic [WINDOW_W-1:0] WINDOW_RESET         = 11'd1;

    // sequencer states
    typedef enum logic [3:0] {
        S_IDLE,
        S_EXP_RD,
        S_EXP_CHK,
        S_POP_RDQ,
        S_POP_RDS,
        S_POP_CHK,
        S_PUSH,
        S_FRONT_RD,
        S_HI_RD,
        S_LO_RD,
        S_SPREAD,
        S_BEST,
        S_DONE
    } state_t;

    // operand selection of the shared subtractor
    typedef enum logic [2:0] {
        ALU_EXPIRE,
        ALU_POP_MAX,
        ALU_POP_MIN,
        ALU_SPREAD,
        ALU_BEST
    } alu_op_t;

    typedef struct packed {
        logic [SAMPLE_W-1:0] diff;
        logic                borrow;
    } alu_res_t;

endpackage

[rtl/swms_ram.sv]
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module swms_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // read port, data held while re is low
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

[rtl/swms_alu.sv]
// Shared 33-bit subtractor with operand selection for all compares.
// Depends on swms_pkg.
module swms_alu import swms_pkg::*; #(
    parameter int CW = 11
) (
    input  alu_op_t             op,
    input  logic [SAMPLE_W-1:0] x,
    input  logic [SAMPLE_W-1:0] smp,
    input  logic [SAMPLE_W-1:0] hi,
    input  logic [SAMPLE_W-1:0] spread,
    input  logic [SAMPLE_W-1:0] best,
    input  logic [CW-1:0]       age,
    input  logic [CW-1:0]       win,
    output alu_res_t            res
);

    logic [SAMPLE_W-1:0] a;
    logic [SAMPLE_W-1:0] b;
    logic [SAMPLE_W:0]   d;

    // operand select
    always_comb
    begin
        unique case (op)
            ALU_EXPIRE:
            begin
                a = SAMPLE_W'(age);
                b = SAMPLE_W'(win);
            end
            ALU_POP_MAX:
            begin
                a = x;
                b = smp;
            end
            ALU_POP_MIN:
            begin
                a = smp;
                b = x;
            end
            ALU_SPREAD:
            begin
                a = hi;
                b = smp;
            end
            ALU_BEST:
            begin
                a = best;
                b = spread;
            end
            default:
            begin
                a = hi;
                b = smp;
            end
        endcase
    end

    // borrow set means a < b
    assign d          = {1'b0, a} - {1'b0, b};
    assign res.diff   = d[SAMPLE_W-1:0];
    assign res.borrow = d[SAMPLE_W];

endmodule

[rtl/sliding_window_max_spread.sv]
// Top level of the sliding window spread block: sequencer, queue rings, sample ring.
// Depends on swms_pkg, swms_ram and swms_alu.
//
// Use: samples arrive on the input channel (in_valid, in_stall, sample, last).
// One item is taken while the block is idle; in_stall then stays high until
// the item is fully processed. The time from an item's accept to the next
// possible accept grows with E, the number of entries that leave the fronts
// of the queues, and P, the number popped from their backs; each entry leaves
// a queue once, so E + P averages at most two per item. This time is set by
// the single shared subtractor and the one read port of each ring.
// Only the item with last set gives a result: best_spread appears on out_valid
// when the processing of that item ends, and the block is idle again in the
// same cycle. The output register holds a result while out_stall is high; a
// later last item waits in its final step until that result is taken.
// The user must see that window_size is written over the APB port only while
// idle; the block itself does not enforce this. 0 acts as 1 and values above
// MAX_WINDOW act as MAX_WINDOW. Reset empties the queues, clears the count and
// best spread and sets window_size to 1; the rings need no clearing.
module sliding_window_max_spread import swms_pkg::*; #(
    parameter int MAX_WINDOW = DEF_MAX_WINDOW
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_stall,
    input  logic [SAMPLE_W-1:0] sample,
    input  logic                last,
    output logic                out_valid,
    input  logic                out_stall,
    output logic [SAMPLE_W-1:0] best_spread,
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [PADDR_W-1:0]  paddr,
    input  logic [PDATA_W-1:0]  pwdata,
    output logic [PDATA_W-1:0]  prdata,
    output logic                pready
);

    localparam int AW = $clog2(MAX_WINDOW);
    localparam int CW = $clog2(MAX_WINDOW + 1);

    state_t              state_reg, state_next;
    logic                side_reg;
    logic [WINDOW_W-1:0] window_reg;
    logic [AW-1:0]       max_head_reg, min_head_reg;
    logic [CW-1:0]       max_size_reg, min_size_reg;
    logic [AW-1:0]       pslot_reg;
    logic [CW-1:0]       count_reg;
    logic [SAMPLE_W-1:0] best_reg;
    logic [SAMPLE_W-1:0] x_reg;
    logic                last_reg;
    logic [SAMPLE_W-1:0] hi_reg;
    logic [SAMPLE_W-1:0] spread_reg;
    logic                out_valid_reg;
    logic [SAMPLE_W-1:0] out_data_reg;

    logic [AW-1:0]       cur_head, cur_back, max_tail, min_tail;
    logic [CW-1:0]       cur_size;
    logic [AW-1:0]       q_rdata_cur;
    logic [CW-1:0]       dist_raw, dist_full, win_eff;
    logic                expire_hit, pop_hit, best_hit, out_free, accept;

    logic                maxq_re, minq_re, smp_re;
    logic [AW-1:0]       maxq_raddr, minq_raddr, maxq_rdata, minq_rdata, smp_raddr;
    logic [SAMPLE_W-1:0] smp_rdata;
    logic                do_expire, do_pop, do_push, do_flip, do_hi, do_spread;
    logic                do_best, do_finish;
    alu_op_t             alu_op;
    alu_res_t            alu_res;

    // ring index addition, sum stays below twice the depth
    function automatic logic [AW-1:0] ring_add(input logic [AW-1:0] a, input logic [CW-1:0] b);
        logic [CW:0] s;
        s = (CW+1)'(a) + (CW+1)'(b);
        if (s >= (CW+1)'(MAX_WINDOW))
        begin
            s = s - (CW+1)'(MAX_WINDOW);
        end
        return s[AW-1:0];
    endfunction

    // configuration port
    assign pready = 1'b1;
    assign prdata = (paddr == REG_WINDOW_SIZE_ADDR) ? PDATA_W'(window_reg) : '0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            window_reg <= WINDOW_RESET;
        end
        else if (psel && penable && pwrite && pready && (paddr == REG_WINDOW_SIZE_ADDR))
        begin
            window_reg <= pwdata[WINDOW_W-1:0];
        end
    end

    // effective window, clamped to 1..MAX_WINDOW
    always_comb
    begin
        priority if (window_reg == '0)
        begin
            win_eff = CW'(1);
        end
        else if (32'(window_reg) > 32'(MAX_WINDOW))
        begin
            win_eff = CW'(MAX_WINDOW);
        end
        else
        begin
            win_eff = CW'(window_reg);
        end
    end

    // selected queue
    assign cur_head    = side_reg ? min_head_reg : max_head_reg;
    assign cur_size    = side_reg ? min_size_reg : max_size_reg;
    assign q_rdata_cur = side_reg ? minq_rdata : maxq_rdata;
    assign cur_back    = ring_add(cur_head, CW'(cur_size - CW'(1)));
    assign max_tail    = ring_add(max_head_reg, max_size_reg);
    assign min_tail    = ring_add(min_head_reg, min_size_reg);

    // age of the front entry; a ring distance of zero means a full ring behind
    assign dist_raw  = (pslot_reg >= q_rdata_cur) ? CW'(pslot_reg - q_rdata_cur)
                     : CW'(MAX_WINDOW) - CW'(q_rdata_cur) + CW'(pslot_reg);
    assign dist_full = (dist_raw == '0) ? CW'(MAX_WINDOW) : dist_raw;

    swms_alu #(.CW(CW)) u_alu (
        .op     (alu_op),
        .x      (x_reg),
        .smp    (smp_rdata),
        .hi     (hi_reg),
        .spread (spread_reg),
        .best   (best_reg),
        .age    (dist_full),
        .win    (win_eff),
        .res    (alu_res)
    );

    assign expire_hit = !alu_res.borrow;
    assign pop_hit    = !alu_res.borrow;
    assign best_hit   = alu_res.borrow && ((count_reg >= win_eff) || last_reg);
    assign out_free   = !out_valid_reg || !out_stall;
    assign in_stall   = (state_reg != S_IDLE);
    assign accept     = in_valid && !in_stall;

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = S_EXP_RD;
                end
            end
            S_EXP_RD:
            begin
                if (cur_size != '0)
                begin
                    state_next = S_EXP_CHK;
                end
                else if (side_reg)
                begin
                    state_next = S_POP_RDQ;
                end
            end
            S_EXP_CHK:
            begin
                if (expire_hit || !side_reg)
                begin
                    state_next = S_EXP_RD;
                end
                else
                begin
                    state_next = S_POP_RDQ;
                end
            end
            S_POP_RDQ:
            begin
                if (cur_size != '0)
                begin
                    state_next = S_POP_RDS;
                end
                else if (side_reg)
                begin
                    state_next = S_PUSH;
                end
            end
            S_POP_RDS:
            begin
                state_next = S_POP_CHK;
            end
            S_POP_CHK:
            begin
                if (pop_hit || !side_reg)
                begin
                    state_next = S_POP_RDQ;
                end
                else
                begin
                    state_next = S_PUSH;
                end
            end
            S_PUSH:     state_next = S_FRONT_RD;
            S_FRONT_RD: state_next = S_HI_RD;
            S_HI_RD:    state_next = S_LO_RD;
            S_LO_RD:    state_next = S_SPREAD;
            S_SPREAD:   state_next = S_BEST;
            S_BEST:     state_next = last_reg ? S_DONE : S_IDLE;
            S_DONE:
            begin
                if (out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:    state_next = S_IDLE;
        endcase
    end

    // control outputs
    always_comb
    begin
        maxq_re    = 1'b0;
        minq_re    = 1'b0;
        smp_re     = 1'b0;
        maxq_raddr = max_head_reg;
        minq_raddr = min_head_reg;
        smp_raddr  = q_rdata_cur;
        alu_op     = ALU_SPREAD;
        do_expire  = 1'b0;
        do_pop     = 1'b0;
        do_push    = 1'b0;
        do_flip    = 1'b0;
        do_hi      = 1'b0;
        do_spread  = 1'b0;
        do_best    = 1'b0;
        do_finish  = 1'b0;
        unique case (state_reg)
            S_EXP_RD:
            begin
                if (cur_size != '0)
                begin
                    maxq_re = !side_reg;
                    minq_re = side_reg;
                end
                else
                begin
                    do_flip = 1'b1;
                end
            end
            S_EXP_CHK:
            begin
                alu_op    = ALU_EXPIRE;
                do_expire = expire_hit;
                do_flip   = !expire_hit;
            end
            S_POP_RDQ:
            begin
                maxq_raddr = cur_back;
                minq_raddr = cur_back;
                if (cur_size != '0)
                begin
                    maxq_re = !side_reg;
                    minq_re = side_reg;
                end
                else
                begin
                    do_flip = 1'b1;
                end
            end
            S_POP_RDS:
            begin
                smp_re = 1'b1;
            end
            S_POP_CHK:
            begin
                alu_op  = side_reg ? ALU_POP_MIN : ALU_POP_MAX;
                do_pop  = pop_hit;
                do_flip = !pop_hit;
            end
            S_PUSH:
            begin
                do_push = 1'b1;
            end
            S_FRONT_RD:
            begin
                maxq_re = 1'b1;
                minq_re = 1'b1;
            end
            S_HI_RD:
            begin
                smp_re    = 1'b1;
                smp_raddr = maxq_rdata;
            end
            S_LO_RD:
            begin
                smp_re    = 1'b1;
                smp_raddr = minq_rdata;
                do_hi     = 1'b1;
            end
            S_SPREAD:
            begin
                alu_op    = ALU_SPREAD;
                do_spread = 1'b1;
            end
            S_BEST:
            begin
                alu_op  = ALU_BEST;
                do_best = best_hit;
            end
            S_DONE:
            begin
                do_finish = out_free;
            end
            default:
            begin
                alu_op = ALU_SPREAD;
            end
        endcase
    end

    // sequencer and queue pointers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            side_reg     <= 1'b0;
            max_head_reg <= '0;
            min_head_reg <= '0;
            max_size_reg <= '0;
            min_size_reg <= '0;
            pslot_reg    <= '0;
            count_reg    <= '0;
            best_reg     <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (do_flip)
            begin
                side_reg <= !side_reg;
            end
            if (do_expire)
            begin
                if (side_reg)
                begin
                    min_head_reg <= ring_add(min_head_reg, CW'(1));
                    min_size_reg <= min_size_reg - CW'(1);
                end
                else
                begin
                    max_head_reg <= ring_add(max_head_reg, CW'(1));
                    max_size_reg <= max_size_reg - CW'(1);
                end
            end
            if (do_pop)
            begin
                if (side_reg)
                begin
                    min_size_reg <= min_size_reg - CW'(1);
                end
                else
                begin
                    max_size_reg <= max_size_reg - CW'(1);
                end
            end
            if (do_push)
            begin
                max_size_reg <= max_size_reg + CW'(1);
                min_size_reg <= min_size_reg + CW'(1);
                pslot_reg    <= ring_add(pslot_reg, CW'(1));
                if (count_reg != CW'(MAX_WINDOW))
                begin
                    count_reg <= count_reg + CW'(1);
                end
            end
            if (do_best)
            begin
                best_reg <= spread_reg;
            end
            // sequence end clears the queue pointers, sample slot, count and best spread
            if (do_finish)
            begin
                max_head_reg <= '0;
                min_head_reg <= '0;
                max_size_reg <= '0;
                min_size_reg <= '0;
                pslot_reg    <= '0;
                count_reg    <= '0;
                best_reg     <= '0;
            end
        end
    end

    // output register valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (do_finish)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            x_reg    <= sample;
            last_reg <= last;
        end
        if (do_hi)
        begin
            hi_reg <= smp_rdata;
        end
        if (do_spread)
        begin
            spread_reg <= alu_res.diff;
        end
        if (do_finish)
        begin
            out_data_reg <= best_reg;
        end
    end

    assign out_valid   = out_valid_reg;
    assign best_spread = out_data_reg;

    // recent samples ring
    swms_ram #(.WIDTH(SAMPLE_W), .DEPTH(MAX_WINDOW)) u_smp_ram (
        .clk   (clk),
        .we    (do_push),
        .waddr (pslot_reg),
        .wdata (x_reg),
        .re    (smp_re),
        .raddr (smp_raddr),
        .rdata (smp_rdata)
    );

    // max queue ring of sample slots
    swms_ram #(.WIDTH(AW), .DEPTH(MAX_WINDOW)) u_maxq_ram (
        .clk   (clk),
        .we    (do_push),
        .waddr (max_tail),
        .wdata (pslot_reg),
        .re    (maxq_re),
        .raddr (maxq_raddr),
        .rdata (maxq_rdata)
    );

    // min queue ring of sample slots
    swms_ram #(.WIDTH(AW), .DEPTH(MAX_WINDOW)) u_minq_ram (
        .clk   (clk),
        .we    (do_push),
        .waddr (min_tail),
        .wdata (pslot_reg),
        .re    (minq_re),
        .raddr (minq_raddr),
        .rdata (minq_rdata)
    );

endmodule

[rtl/swms_checker.sv]
// Port-level checks for the sliding window spread block, bound to the top level.
// Depends on sliding_window_max_spread_defines.svh.
`include "sliding_window_max_spread_defines.svh"

module swms_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        in_valid,
    input logic        in_stall,
    input logic        out_valid,
    input logic        out_stall,
    input logic [31:0] best_spread
);

    // a taken item keeps the block busy in the next cycle
    `SWMS_ASSERT_NEXT(a_busy_after_accept, in_valid && !in_stall, in_stall)

    // a result only comes out of a busy block
    `SWMS_ASSERT_IMP(a_result_from_busy, $rose(out_valid), $past(in_stall))

    // the block is idle again once the result is posted
    `SWMS_ASSERT_IMP(a_idle_with_result, $rose(out_valid), !in_stall)

    // a stalled result holds
    `SWMS_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(best_spread))

endmodule

bind sliding_window_max_spread swms_checker u_swms_checker (.*);

[bench/sliding_window_max_spread_chk.sv]
// Checker for the sliding window spread block: follows the window register over APB,
// predicts best_spread for every sequence and compares each result item as it is taken.
// Depends on swms_pkg; instantiated beside the block by sliding_window_max_spread_tb.
module sliding_window_max_spread_chk import swms_pkg::*; (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    input  logic                in_stall,
    input  logic [SAMPLE_W-1:0] sample,
    input  logic                last,
    input  logic                out_valid,
    input  logic                out_stall,
    input  logic [SAMPLE_W-1:0] best_spread,
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [PADDR_W-1:0]  paddr,
    input  logic [PDATA_W-1:0]  pwdata,
    input  logic                pready,
    output int                  errors,
    output int                  pending
);
    timeunit 1ns;
    timeprecision 1ps;

    // a queue entry keeps the sample value alongside its position in the sequence
    typedef struct {
        logic [SAMPLE_W-1:0] pos;
        logic [SAMPLE_W-1:0] value;
    } window_entry_t;

    window_entry_t       peak_q[$];      // decreasing values, front is the window maximum
    window_entry_t       trough_q[$];    // increasing values, front is the window minimum
    logic [SAMPLE_W-1:0] spread_due[$];  // best spreads still to come out
    logic [WINDOW_W-1:0] window_reg;
    logic [SAMPLE_W-1:0] next_pos;
    logic [SAMPLE_W-1:0] seq_len;
    logic [SAMPLE_W-1:0] widest;
    int                  mismatches;

    function automatic void clear_sequence();
        peak_q.delete();
        trough_q.delete();
        next_pos = '0;
        seq_len  = '0;
        widest   = '0;
    endfunction

    // advance the window by one sample; a last sample closes the sequence
    function automatic void absorb_sample(input logic [SAMPLE_W-1:0] x, input logic is_last);
        logic [SAMPLE_W-1:0] span;
        logic [SAMPLE_W-1:0] spread;
        if (window_reg == '0)
            span = 1;
        else if (window_reg > DEF_MAX_WINDOW)
            span = DEF_MAX_WINDOW;
        else
            span = SAMPLE_W'(window_reg);

        // drop positions that have slid out of the window ending here
        while (peak_q.size() > 0 && next_pos - peak_q[0].pos >= span)
            void'(peak_q.pop_front());
        while (trough_q.size() > 0 && next_pos - trough_q[0].pos >= span)
            void'(trough_q.pop_front());

        // entries beaten by the new sample can never be a window extreme again
        while (peak_q.size() > 0 && peak_q[$].value <= x)
            void'(peak_q.pop_back());
        while (trough_q.size() > 0 && trough_q[$].value >= x)
            void'(trough_q.pop_back());

        if (peak_q.size() < DEF_MAX_WINDOW)
            peak_q.push_back('{next_pos, x});
        if (trough_q.size() < DEF_MAX_WINDOW)
            trough_q.push_back('{next_pos, x});

        next_pos = next_pos + 1;
        if (seq_len != '1)
            seq_len = seq_len + 1;

        // a short sequence counts as a single window of everything seen
        spread = peak_q[0].value - trough_q[0].value;
        if ((seq_len >= span || is_last) && spread > widest)
            widest = spread;

        if (is_last)
        begin
            spread_due.push_back(widest);
            clear_sequence();
        end
    endfunction

    // watch the register port, the result channel and the sample channel
    always @(posedge clk or negedge rst_n)
    begin
        logic [SAMPLE_W-1:0] wanted;
        if (!rst_n)
        begin
            window_reg = WINDOW_RESET;
            clear_sequence();
            spread_due.delete();
            mismatches = 0;
        end
        else
        begin
            if (psel && penable && pwrite && pready && paddr == REG_WINDOW_SIZE_ADDR)
                window_reg = pwdata[WINDOW_W-1:0];

            if (out_valid && !out_stall)
            begin
                if (spread_due.size() == 0)
                begin
                    mismatches++;
                    $display("%0t: unexpected best_spread item: expected none, got %0d",
                             $time, best_spread);
                end
                else
                begin
                    wanted = spread_due.pop_front();
                    if (best_spread !== wanted)
                    begin
                        mismatches++;
                        $display("%0t: best_spread mismatch: expected %0d, got %0d",
                                 $time, wanted, best_spread);
                    end
                end
            end

            if (in_valid && !in_stall)
                absorb_sample(sample, last);
        end
        errors  <= mismatches;
        pending <= spread_due.size();
    end

endmodule

[bench/sliding_window_max_spread_tb.sv]
// Top of the sliding window spread bench: clock, reset, sample stimulus, window writes,
// random output stalls, a no-progress watchdog and the verdict.
// Depends on swms_pkg, the block itself and sliding_window_max_spread_chk.
module sliding_window_max_spread_tb;
    timeunit 1ns;
    timeprecision 1ps;
    import swms_pkg::*;

    localparam int WATCHDOG_LIMIT = 20000;
    localparam int SETTLE_CYCLES  = 32;
    localparam int RANDOM_ITEMS   = 500;
    localparam int MIN_SEQUENCES  = 40;
    localparam int RING_ITEMS     = 1100;
    localparam int FALLING_ITEMS  = 700;

    // how the samples of one random sequence are made up
    typedef enum int {
        FILL_RANDOM,
        FILL_NARROW,
        FILL_EXTREME,
        FILL_RISING,
        FILL_FALLING
    } fill_t;

    logic                clk = 1'b0;
    logic                rst_n;
    logic                in_valid;
    logic                in_stall;
    logic [SAMPLE_W-1:0] sample;
    logic                last;
    logic                out_valid;
    logic                out_stall = 1'b0;
    logic [SAMPLE_W-1:0] best_spread;
    logic                psel;
    logic                penable;
    logic                pwrite;
    logic [PADDR_W-1:0]  paddr;
    logic [PDATA_W-1:0]  pwdata;
    logic [PDATA_W-1:0]  prdata;
    logic                pready;

    int   errors;
    int   pending;
    logic quiet;
    int   sent_items;
    int   idle_cycles;
    int   stall_left;
    int   stall_span;

    sliding_window_max_spread i_dut (.*);

    sliding_window_max_spread_chk i_chk (.*);

    always #1 clk = ~clk;

    // mostly no gap, often a short one, now and then a long one
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (quiet || r < 55)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        return $urandom_range(4, 40);
    endfunction

    function automatic logic [WINDOW_W-1:0] pick_window();
        int r;
        r = $urandom_range(0, 99);
        if (r < 45)
            return WINDOW_W'($urandom_range(1, 8));
        if (r < 65)
            return WINDOW_W'($urandom_range(9, 64));
        if (r < 75)
            return '0;
        if (r < 80)
            return WINDOW_W'(DEF_MAX_WINDOW);
        if (r < 85)
            return '1;
        if (r < 90)
            return WINDOW_W'($urandom_range(DEF_MAX_WINDOW + 1, 2046));
        return WINDOW_W'($urandom_range(65, DEF_MAX_WINDOW - 1));
    endfunction

    function automatic logic [SAMPLE_W-1:0] fill_value(input fill_t fill, input int idx,
                                                       input logic [SAMPLE_W-1:0] base,
                                                       input logic [SAMPLE_W-1:0] step);
        unique case (fill)
            FILL_NARROW:  return SAMPLE_W'($urandom_range(0, 7));
            FILL_EXTREME: return ($urandom_range(0, 1) != 0) ? '1 : '0;
            FILL_RISING:  return base + step * SAMPLE_W'(idx);
            FILL_FALLING: return base - step * SAMPLE_W'(idx);
            default:      return SAMPLE_W'($urandom());
        endcase
    endfunction

    // present one item after a random gap and hold it until it is taken
    task automatic send_sample(input logic [SAMPLE_W-1:0] value, input logic is_last);
        int gap;
        gap = pick_gap();
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        sample   <= value;
        last     <= is_last;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        sent_items++;
    endtask

    // wait for the block to drain, then write the window register
    task automatic set_window(input logic [WINDOW_W-1:0] w);
        logic [PDATA_W-1:0] upper;
        upper    = $urandom();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        while (in_stall)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= REG_WINDOW_SIZE_ADDR;
        pwdata  <= {upper[PDATA_W-1:WINDOW_W], w};
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    // result side: stall bursts of random length
    always @(posedge clk)
    begin
        if (stall_left > 0)
        begin
            stall_left <= stall_left - 1;
        end
        else
        begin
            stall_span = pick_gap();
            out_stall  <= (stall_span > 0);
            stall_left <= (stall_span > 0) ? stall_span - 1 : 0;
        end
    end

    // give up when no item moves on either channel for too long
    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("simulation failed");
            $finish;
        end
    end

    initial
    begin
        fill_t               fill;
        int                  length;
        int                  change_at;
        int                  sequences;
        logic [SAMPLE_W-1:0] base;
        logic [SAMPLE_W-1:0] step;

        rst_n      = 1'b0;
        in_valid   = 1'b0;
        sample     = '0;
        last       = 1'b0;
        psel       = 1'b0;
        penable    = 1'b0;
        pwrite     = 1'b0;
        paddr      = '0;
        pwdata     = '0;
        quiet      = 1'b0;
        sent_items = 0;
        sequences  = 0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // one-sample sequence under the reset window
        send_sample('1, 1'b1);
        send_sample('0, 1'b0);
        send_sample('1, 1'b1);

        // zero window behaves as a window of one
        set_window('0);
        send_sample(32'd5, 1'b0);
        send_sample(32'd7, 1'b0);
        send_sample(32'd3, 1'b1);

        // full-scale values across a window of three
        set_window(WINDOW_W'(3));
        send_sample('0, 1'b0);
        send_sample('1, 1'b0);
        send_sample(32'h8000_0000, 1'b0);
        send_sample(32'd1, 1'b0);
        send_sample(32'd1, 1'b1);

        // oversized window, sequence shorter than the window, repeated values
        set_window('1);
        send_sample(32'd10, 1'b0);
        send_sample(32'd3, 1'b0);
        send_sample(32'd10, 1'b0);
        send_sample(32'd3, 1'b1);

        set_window(WINDOW_W'(DEF_MAX_WINDOW + 1));
        send_sample('1, 1'b0);
        send_sample('0, 1'b1);

        // window shrinks part way through a sequence
        set_window(WINDOW_W'(4));
        send_sample(32'd1, 1'b0);
        send_sample(32'd100, 1'b0);
        send_sample(32'd2, 1'b0);
        send_sample(32'd3, 1'b0);
        set_window(WINDOW_W'(2));
        send_sample(32'd4, 1'b0);
        send_sample(32'd5, 1'b1);

        // largest window over a sequence long enough to wrap the sample ring:
        // a long falling run fills the maximum queue, random values then flush it
        set_window(WINDOW_W'(DEF_MAX_WINDOW));
        for (int i = 0; i < RING_ITEMS; i++)
        begin
            if (i < FALLING_ITEMS)
                base = 32'hF000_0000 - SAMPLE_W'(3 * i);
            else
                base = $urandom();
            send_sample(base, i == RING_ITEMS - 1);
        end

        // random sequences with random windows
        sent_items = 0;
        while (sent_items < RANDOM_ITEMS || sequences < MIN_SEQUENCES)
        begin
            quiet <= ($urandom_range(0, 4) == 0);
            if ($urandom_range(0, 9) < 4)
                set_window(pick_window());
            if ($urandom_range(0, 4) == 0)
                length = $urandom_range(17, 60);
            else
                length = $urandom_range(1, 16);
            fill      = fill_t'($urandom_range(0, 4));
            base      = $urandom();
            step      = SAMPLE_W'($urandom_range(1, 1 << $urandom_range(0, 20)));
            change_at = -1;
            if (length > 1 && $urandom_range(0, 9) == 0)
                change_at = $urandom_range(1, length - 1);
            for (int i = 0; i < length; i++)
            begin
                if (i == change_at)
                    set_window(pick_window());
                send_sample(fill_value(fill, i, base, step), i == length - 1);
            end
            sequences++;
        end

        // drain and decide
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        while (in_stall)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (errors == 0 && pending == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule

[sim.f]
+incdir+rtl
rtl/swms_pkg.sv
rtl/swms_ram.sv
rtl/swms_alu.sv
rtl/sliding_window_max_spread.sv
rtl/swms_checker.sv
bench/sliding_window_max_spread_chk.sv
bench/sliding_window_max_spread_tb.sv
